>>> hdl/doqt_pkg.sv
// Shared types and command codes for the depth occluder query table.
`timescale 1ns / 1ps

package doqt_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUAD  = 2'd2,
    CMD_POINT = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [15:0] corner_x0;
    logic signed [15:0] corner_y0;
    logic signed [15:0] corner_x1;
    logic signed [15:0] corner_y1;
    logic signed [15:0] corner_x2;
    logic signed [15:0] corner_y2;
    logic signed [15:0] corner_x3;
    logic signed [15:0] corner_y3;
    logic [15:0]        depth;
  } in_item_t;

  typedef struct packed {
    logic occluded;
    logic table_full;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] ymax;
    logic signed [15:0] xmax;
    logic signed [15:0] ymin;
    logic signed [15:0] xmin;
  } box_t;

  typedef struct packed {
    box_t        box;
    logic [15:0] depth;
  } entry_t;

  // A query travelling along the row of cells.
  typedef struct packed {
    logic        vld;
    logic        point;
    logic        occ;
    logic [15:0] depth;
    box_t        box;
  } probe_t;

endpackage

>>> hdl/doqt_bbox.sv
// Axis-aligned bounding box of the four corners of a quad.
`timescale 1ns / 1ps

module doqt_bbox
  import doqt_pkg::*;
(
  input  in_item_t item,
  output box_t     box
);

  logic signed [15:0] xlo_a, xlo_b, xhi_a, xhi_b;
  logic signed [15:0] ylo_a, ylo_b, yhi_a, yhi_b;

  // Two-level min/max tree on each axis.
  always_comb begin
    xlo_a = (item.corner_x1 < item.corner_x0) ? item.corner_x1 : item.corner_x0;
    xhi_a = (item.corner_x1 > item.corner_x0) ? item.corner_x1 : item.corner_x0;
    xlo_b = (item.corner_x3 < item.corner_x2) ? item.corner_x3 : item.corner_x2;
    xhi_b = (item.corner_x3 > item.corner_x2) ? item.corner_x3 : item.corner_x2;
    ylo_a = (item.corner_y1 < item.corner_y0) ? item.corner_y1 : item.corner_y0;
    yhi_a = (item.corner_y1 > item.corner_y0) ? item.corner_y1 : item.corner_y0;
    ylo_b = (item.corner_y3 < item.corner_y2) ? item.corner_y3 : item.corner_y2;
    yhi_b = (item.corner_y3 > item.corner_y2) ? item.corner_y3 : item.corner_y2;
    box.xmin = (xlo_b < xlo_a) ? xlo_b : xlo_a;
    box.xmax = (xhi_b > xhi_a) ? xhi_b : xhi_a;
    box.ymin = (ylo_b < ylo_a) ? ylo_b : ylo_a;
    box.ymax = (yhi_b > yhi_a) ? yhi_b : yhi_a;
  end

endmodule

>>> hdl/doqt_cell.sv
// One table cell: holds an occluder and tests the passing query against it.
`timescale 1ns / 1ps

module doqt_cell
  import doqt_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  entry_t           wr_entry,
  input  logic [CNT_W-1:0] count,
  input  probe_t           probe_i,
  output probe_t           probe_o
);

  entry_t entry_r;
  probe_t probe_r;
  probe_t probe_nxt;
  logic   active;
  logic   nearer;
  logic   ovl_x;
  logic   ovl_y;

  assign active = count > CNT_W'(IDX);
  assign nearer = entry_r.depth < probe_i.depth;

  // A point query carries a zero-size box, so an inclusive test on it is the
  // edge-inclusive point-in-box check; a quad needs strictly positive overlap.
  always_comb begin
    if (probe_i.point) begin
      ovl_x = (entry_r.box.xmin <= probe_i.box.xmin) &&
              (probe_i.box.xmax <= entry_r.box.xmax);
      ovl_y = (entry_r.box.ymin <= probe_i.box.ymin) &&
              (probe_i.box.ymax <= entry_r.box.ymax);
    end else begin
      ovl_x = (probe_i.box.xmin < probe_i.box.xmax) &&
              (entry_r.box.xmin < entry_r.box.xmax) &&
              (probe_i.box.xmin < entry_r.box.xmax) &&
              (entry_r.box.xmin < probe_i.box.xmax);
      ovl_y = (probe_i.box.ymin < probe_i.box.ymax) &&
              (entry_r.box.ymin < entry_r.box.ymax) &&
              (probe_i.box.ymin < entry_r.box.ymax) &&
              (entry_r.box.ymin < probe_i.box.ymax);
    end
    probe_nxt     = probe_i;
    probe_nxt.occ = probe_i.occ | (probe_i.vld & active & nearer & ovl_x & ovl_y);
  end

  always_ff @(posedge clk) begin
    if (wr_en && (count == CNT_W'(IDX))) begin
      entry_r <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_nxt.vld;
    end
    probe_r.point <= probe_nxt.point;
    probe_r.occ   <= probe_nxt.occ;
    probe_r.depth <= probe_nxt.depth;
    probe_r.box   <= probe_nxt.box;
  end

  assign probe_o = probe_r;

endmodule

>>> hdl/depth_occluder_query_table.sv
// Top level of the depth occluder query table: command decode and cell row.
`timescale 1ns / 1ps

// Usage
// A command beat is taken at a rising edge with start high and busy low.
// in_data.cmd selects clear, add occluder, quad query or point query.
// Every command gives exactly one result beat: out_valid is high for one
// cycle with out_data; the receiver must take it then, it cannot stall.
// Clear and add answer in the cycle after the command and busy stays low, so
// they may follow each other every cycle. An add into a full table is
// dropped and answers with table_full set.
// A query enters a row of MAX_OCCLUDERS cells, one occluder per cell, and
// moves one cell per cycle; each cell compares its occluder with it. The
// answer is registered once the query has left the last cell, and busy
// stays high while the query is in the row, so a new command waits until
// the answer is given.
// Reset empties the table (entry count zero) and drops any query in flight;
// the stored occluders themselves are not cleared.
module depth_occluder_query_table
  import doqt_pkg::*;
#(
  parameter int MAX_OCCLUDERS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(MAX_OCCLUDERS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  box_t             quad_box;
  probe_t           probe_in;
  probe_t           link [MAX_OCCLUDERS+1];
  logic [MAX_OCCLUDERS-1:0] probe_vld;
  logic             accept;
  logic             is_query;
  logic             is_full;
  logic             wr_en;
  entry_t           wr_entry;

  doqt_bbox u_bbox (
    .item (in_data),
    .box  (quad_box)
  );

  assign accept   = start && (state_r == ST_IDLE);
  assign is_query = (in_data.cmd == CMD_QUAD) || (in_data.cmd == CMD_POINT);
  assign is_full  = count_r == CNT_W'(MAX_OCCLUDERS);
  assign wr_en    = accept && (in_data.cmd == CMD_ADD) && !is_full;

  assign wr_entry.box   = quad_box;
  assign wr_entry.depth = in_data.depth;

  always_comb begin
    probe_in.vld   = accept && is_query;
    probe_in.point = in_data.cmd == CMD_POINT;
    probe_in.occ   = 1'b0;
    probe_in.depth = in_data.depth;
    if (in_data.cmd == CMD_POINT) begin
      probe_in.box.xmin = in_data.corner_x0;
      probe_in.box.xmax = in_data.corner_x0;
      probe_in.box.ymin = in_data.corner_y0;
      probe_in.box.ymax = in_data.corner_y0;
    end else begin
      probe_in.box = quad_box;
    end
  end

  assign link[0] = probe_in;

  for (genvar i = 0; i < MAX_OCCLUDERS; i++) begin : g_cell
    doqt_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en),
      .wr_entry (wr_entry),
      .count    (count_r),
      .probe_i  (link[i]),
      .probe_o  (link[i+1])
    );
    assign probe_vld[i] = link[i+1].vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.cmd)
              CMD_CLEAR: begin
                count_r     <= '0;
                out_valid_r <= 1'b1;
                out_data_r  <= '0;
              end
              CMD_ADD: begin
                if (!is_full) begin
                  count_r <= count_r + CNT_W'(1);
                end
                out_valid_r           <= 1'b1;
                out_data_r.occluded   <= 1'b0;
                out_data_r.table_full <= is_full;
              end
              default: begin
                state_r <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          // The query has left the last cell carrying the combined verdict.
          if (link[MAX_OCCLUDERS].vld) begin
            state_r               <= ST_IDLE;
            out_valid_r           <= 1'b1;
            out_data_r.occluded   <= link[MAX_OCCLUDERS].occ;
            out_data_r.table_full <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only one query is ever in the row of cells.
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(probe_vld) <= 1)
    else $error("more than one query in the cell row");

  // A query only travels while the block reports busy.
  a_probe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (probe_vld != '0) |-> busy)
    else $error("query in flight while idle");

  // A dropped add is only reported when the table is full.
  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_full) |->
      (count_r == CNT_W'(MAX_OCCLUDERS)) && !out_data.occluded)
    else $error("table_full reported below capacity");

  // Entry count never exceeds the capacity of the row.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_OCCLUDERS))
    else $error("entry count beyond capacity");

endmodule
